// File: sv/tlpfs_pkg.sv
// tlpfs_pkg: types and codes shared by the three-level priority fifo scheduler
// no dependencies

package tlpfs_pkg;

	localparam int NUM_LEVELS = 3;
	localparam int LEVEL_W    = 2;
	localparam int PID_W      = 16;
	localparam int COUNT_W    = 5;

	typedef enum logic [1:0] {
		KIND_ENQUEUE  = 2'd0,
		KIND_SCHEDULE = 2'd1,
		KIND_DEQUEUE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_BADLEVEL = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [LEVEL_W-1:0] level;
		logic [PID_W-1:0]   proc_id;
	} req_t;

	typedef struct packed {
		logic [PID_W-1:0]   popped_id;
		logic               popped_valid;
		logic [LEVEL_W-1:0] from_level;
		logic [1:0]         status;
		logic [COUNT_W-1:0] count_high;
		logic [COUNT_W-1:0] count_mid;
		logic [COUNT_W-1:0] count_low;
	} rsp_t;

endpackage

// File: sv/three_level_priority_fifo_scheduler.sv
// three_level_priority_fifo_scheduler: top level, three fifo queues in one store
// depends on tlpfs_pkg
//
// Three FIFO queues of process identifiers, queue 0 the most urgent, each holding up to
// DEPTH entries in one shared store. A request enqueues at a level, dequeues from a level,
// or schedules (pops the head of the most urgent non-empty queue); each request gives one
// result with the popped identifier, its level, a status and the three occupancy counts
// after the operation. A request is decided and applied at the edge it is accepted, and
// its result is held in the output register from the next cycle on. A new request is
// taken whenever the output register is empty or its result is taken in the same cycle,
// so one request per cycle is sustained; each request uses at most one of the store's
// single read and single write ports.

module three_level_priority_fifo_scheduler
	import tlpfs_pkg::*;
#(
	parameter int DEPTH    = 16,
	parameter int ID_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ENTRIES = NUM_LEVELS * DEPTH;
	localparam int ADDR_W = $clog2(ENTRIES);

	logic [ID_WIDTH-1:0] store [ENTRIES];

	logic [PTR_W-1:0] head_q [NUM_LEVELS];
	logic [PTR_W-1:0] tail_q [NUM_LEVELS];
	logic [CNT_W-1:0] occ_q  [NUM_LEVELS];

	logic                rsp_valid_q;
	logic [ID_WIDTH-1:0] rd_q;
	logic                popped_q;
	logic [LEVEL_W-1:0]  from_q;
	status_t             status_q;

	logic               accept;
	logic [3:0]         empty_v;
	logic [3:0]         full_v;
	logic               lvl_ok;
	logic               do_push;
	logic               do_pop;
	logic [LEVEL_W-1:0] sel_lvl;
	logic [LEVEL_W-1:0] from_d;
	status_t            status_d;
	logic [PTR_W-1:0]   head_sel;
	logic [PTR_W-1:0]   tail_sel;
	logic [ADDR_W-1:0]  base_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		empty_v = 4'b0000;
		full_v  = 4'b0000;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			empty_v[i] = (occ_q[i] == '0);
			full_v[i]  = (occ_q[i] == CNT_W'(DEPTH));
		end
	end

	assign lvl_ok = (req.level < LEVEL_W'(NUM_LEVELS));

	// decide the operation against the current queue state
	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		sel_lvl  = '0;
		from_d   = '0;
		status_d = ST_OK;
		case (req.kind)
			KIND_ENQUEUE: begin
				if (!lvl_ok) begin
					status_d = ST_BADLEVEL;
				end else begin
					from_d  = req.level;
					sel_lvl = req.level;
					if (full_v[req.level]) begin
						status_d = ST_FULL;
					end else begin
						do_push = 1'b1;
					end
				end
			end
			KIND_SCHEDULE: begin
				if (!empty_v[0]) begin
					do_pop  = 1'b1;
					sel_lvl = LEVEL_W'(0);
				end else if (!empty_v[1]) begin
					do_pop  = 1'b1;
					sel_lvl = LEVEL_W'(1);
				end else if (!empty_v[2]) begin
					do_pop  = 1'b1;
					sel_lvl = LEVEL_W'(2);
				end else begin
					status_d = ST_EMPTY;
				end
				from_d = sel_lvl;
			end
			KIND_DEQUEUE: begin
				if (!lvl_ok) begin
					status_d = ST_BADLEVEL;
				end else begin
					from_d  = req.level;
					sel_lvl = req.level;
					if (empty_v[req.level]) begin
						status_d = ST_EMPTY;
					end else begin
						do_pop = 1'b1;
					end
				end
			end
			default: begin
				status_d = ST_BADLEVEL;
			end
		endcase
	end

	always_comb begin
		head_sel  = '0;
		tail_sel  = '0;
		base_addr = '0;
		case (sel_lvl)
			2'd0: begin
				head_sel  = head_q[0];
				tail_sel  = tail_q[0];
				base_addr = '0;
			end
			2'd1: begin
				head_sel  = head_q[1];
				tail_sel  = tail_q[1];
				base_addr = ADDR_W'(DEPTH);
			end
			2'd2: begin
				head_sel  = head_q[2];
				tail_sel  = tail_q[2];
				base_addr = ADDR_W'(2 * DEPTH);
			end
			default: begin
				head_sel  = '0;
				tail_sel  = '0;
				base_addr = '0;
			end
		endcase
	end

	assign rd_addr = base_addr + ADDR_W'(head_sel);
	assign wr_addr = base_addr + ADDR_W'(tail_sel);

	// queue store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			store[wr_addr] <= ID_WIDTH'(req.proc_id);
		end
		if (accept && do_pop) begin
			rd_q <= store[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
			rsp_valid_q <= 1'b0;
			popped_q    <= 1'b0;
			from_q      <= '0;
			status_q    <= ST_OK;
		end else begin
			if (accept) begin
				for (int i = 0; i < NUM_LEVELS; i++) begin
					if (sel_lvl == LEVEL_W'(i)) begin
						if (do_push) begin
							tail_q[i] <= (tail_q[i] == PTR_W'(DEPTH - 1)) ? '0
								: tail_q[i] + PTR_W'(1);
							occ_q[i]  <= occ_q[i] + CNT_W'(1);
						end
						if (do_pop) begin
							head_q[i] <= (head_q[i] == PTR_W'(DEPTH - 1)) ? '0
								: head_q[i] + PTR_W'(1);
							occ_q[i]  <= occ_q[i] - CNT_W'(1);
						end
					end
				end
				rsp_valid_q <= 1'b1;
				popped_q    <= do_pop;
				from_q      <= from_d;
				status_q    <= status_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// counts come straight from the occupancy registers, which hold the post-op
	// values for as long as the transaction waits
	assign rsp_valid        = rsp_valid_q;
	assign rsp.popped_id    = popped_q ? PID_W'(rd_q) : '0;
	assign rsp.popped_valid = popped_q;
	assign rsp.from_level   = from_q;
	assign rsp.status       = status_q;
	assign rsp.count_high   = COUNT_W'(occ_q[0]);
	assign rsp.count_mid    = COUNT_W'(occ_q[1]);
	assign rsp.count_low    = COUNT_W'(occ_q[2]);

endmodule

// File: bench/tb_three_level_priority_fifo_scheduler.sv
// tb_three_level_priority_fifo_scheduler: self-checking bench for the three-level scheduler
// depends on tlpfs_pkg and three_level_priority_fifo_scheduler; predicts every result
// from its own copy of the three queues and checks them in order under random idling

module tb_three_level_priority_fifo_scheduler;
	import tlpfs_pkg::*;

	localparam int QDEPTH = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1620;
	localparam int MAX_REPORTS = 10;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_BAD = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	three_level_priority_fifo_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// shadow copy of the three queues
	logic [PID_W-1:0] id_mem [NUM_LEVELS][QDEPTH];
	int rd_idx [NUM_LEVELS];
	int wr_idx [NUM_LEVELS];
	int fill   [NUM_LEVELS];

	req_t pending_reqs [$];
	rsp_t rsp_expected [$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_reqs = 0;
	int rx_hold_done = 0;
	int rx_hold_left = 0;
	logic req_accepted = 1'b0;

	int mismatches = 0;
	int reqs_taken = 0;
	int results_taken = 0;
	int status_seen [4];

	function automatic logic take_head(int lv, output logic [PID_W-1:0] id);
		id = '0;
		if (fill[lv] == 0)
			return 1'b0;
		id = id_mem[lv][rd_idx[lv]];
		rd_idx[lv] = (rd_idx[lv] + 1) % QDEPTH;
		fill[lv]--;
		return 1'b1;
	endfunction

	function automatic rsp_t schedule_step(req_t r);
		rsp_t o;
		int lv;
		logic [PID_W-1:0] id;
		o = '0;
		o.status = ST_OK;
		lv = int'(r.level);
		case (r.kind)
			KIND_ENQUEUE: begin
				if (r.level == LEVEL_BAD) begin
					o.status = ST_BADLEVEL;
				end else begin
					o.from_level = r.level;
					if (fill[lv] == QDEPTH) begin
						o.status = ST_FULL;
					end else begin
						id_mem[lv][wr_idx[lv]] = r.proc_id;
						wr_idx[lv] = (wr_idx[lv] + 1) % QDEPTH;
						fill[lv]++;
					end
				end
			end
			KIND_SCHEDULE: begin
				o.status = ST_EMPTY;
				for (int l = 0; l < NUM_LEVELS; l++) begin
					if (o.status == ST_EMPTY && take_head(l, id)) begin
						o.popped_id = id;
						o.popped_valid = 1'b1;
						o.from_level = LEVEL_W'(l);
						o.status = ST_OK;
					end
				end
			end
			KIND_DEQUEUE: begin
				if (r.level == LEVEL_BAD) begin
					o.status = ST_BADLEVEL;
				end else begin
					o.from_level = r.level;
					if (take_head(lv, id)) begin
						o.popped_id = id;
						o.popped_valid = 1'b1;
					end else begin
						o.status = ST_EMPTY;
					end
				end
			end
			default: begin
				o.status = ST_BADLEVEL;
			end
		endcase
		o.count_high = COUNT_W'(fill[0]);
		o.count_mid = COUNT_W'(fill[1]);
		o.count_low = COUNT_W'(fill[2]);
		return o;
	endfunction

	task automatic check_result(rsp_t got);
		rsp_t want;
		if (rsp_expected.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("unexpected result at %0t: id %h valid %b level %0d status %0d",
					$realtime, got.popped_id, got.popped_valid, got.from_level, got.status);
		end else begin
			want = rsp_expected.pop_front();
			status_seen[want.status]++;
			if (got.popped_id !== want.popped_id || got.popped_valid !== want.popped_valid ||
					got.from_level !== want.from_level || got.status !== want.status ||
					got.count_high !== want.count_high || got.count_mid !== want.count_mid ||
					got.count_low !== want.count_low) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch at %0t (expected / actual):", $realtime);
					$display("  id %h/%h valid %b/%b level %0d/%0d status %0d/%0d",
						want.popped_id, got.popped_id, want.popped_valid, got.popped_valid,
						want.from_level, got.from_level, want.status, got.status);
					$display("  counts %0d %0d %0d / %0d %0d %0d",
						want.count_high, want.count_mid, want.count_low,
						got.count_high, got.count_mid, got.count_low);
				end
			end
		end
	endtask

	// monitor and predictor: results first, then the transaction accepted at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				check_result(rsp);
				results_taken++;
			end
			if (req_valid && !req_stall) begin
				rsp_expected.push_back(schedule_step(req));
				reqs_taken++;
			end
		end
		req_accepted <= arst_n && req_valid && !req_stall;
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_accepted) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result side stall, with long hold-offs on request
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rsp_stall <= 1'b1;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_done != rx_hold_reqs) begin
			rsp_stall <= 1'b1;
			rx_hold_left <= HOLD_CYCLES - 1;
			rx_hold_done <= rx_hold_done + 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	task automatic add_req(logic [1:0] k, logic [LEVEL_W-1:0] lv, logic [PID_W-1:0] id);
		req_t r;
		r.kind = k;
		r.level = lv;
		r.proc_id = id;
		pending_reqs.push_back(r);
	endtask

	// bursts lean toward filling or draining so that full and empty queues both occur
	task automatic add_random_reqs(int n);
		int left;
		int burst;
		int enq_pct;
		int focus;
		int p;
		logic [LEVEL_W-1:0] lv;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(12, 40);
			if (burst > left)
				burst = left;
			case ($urandom_range(2))
				0: enq_pct = 80;
				1: enq_pct = 15;
				default: enq_pct = 50;
			endcase
			focus = $urandom_range(3);
			for (int i = 0; i < burst; i++) begin
				p = $urandom_range(99);
				if (p < 5) begin
					add_req(2'($urandom_range(3)), LEVEL_W'($urandom_range(3)),
						PID_W'($urandom));
				end else if (p < 5 + enq_pct) begin
					lv = (focus < NUM_LEVELS) ? LEVEL_W'(focus)
						: LEVEL_W'($urandom_range(NUM_LEVELS - 1));
					add_req(KIND_ENQUEUE, lv, PID_W'($urandom));
				end else if ($urandom_range(1)) begin
					add_req(KIND_SCHEDULE, LEVEL_W'($urandom_range(3)), PID_W'($urandom));
				end else begin
					add_req(KIND_DEQUEUE, LEVEL_W'($urandom_range(NUM_LEVELS - 1)),
						PID_W'($urandom));
				end
			end
			left -= burst;
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_valid || rsp_expected.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			rd_idx[l] = 0;
			wr_idx[l] = 0;
			fill[l] = 0;
		end
		for (int s = 0; s < 4; s++)
			status_seen[s] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// empty queues, bad levels, unknown kind, id extremes, a full queue
		add_req(KIND_SCHEDULE, 2'd0, 16'h0000);
		add_req(KIND_DEQUEUE, 2'd1, 16'h0000);
		add_req(KIND_ENQUEUE, LEVEL_BAD, 16'hFFFF);
		add_req(KIND_DEQUEUE, LEVEL_BAD, 16'h0000);
		add_req(KIND_UNKNOWN, 2'd1, 16'hAAAA);
		add_req(KIND_ENQUEUE, 2'd2, 16'h0000);
		add_req(KIND_ENQUEUE, 2'd1, 16'hFFFF);
		for (int i = 0; i <= QDEPTH; i++)
			add_req(KIND_ENQUEUE, 2'd0, 16'h5A00 + PID_W'(i));
		add_req(KIND_SCHEDULE, LEVEL_BAD, 16'h1234);
		add_req(KIND_DEQUEUE, 2'd2, 16'h0000);
		add_req(KIND_DEQUEUE, 2'd1, 16'h0000);
		wait_drained();

		// no idling, with a long result hold-off that backs up the input
		add_random_reqs(RANDOM_ITEMS / 8);
		rx_hold_reqs++;
		add_random_reqs(RANDOM_ITEMS / 8);
		wait_drained();

		tx_idle_pct = 82;
		add_random_reqs(RANDOM_ITEMS / 4);
		wait_drained();

		tx_idle_pct = 0;
		rx_stall_pct = 82;
		add_random_reqs(RANDOM_ITEMS / 4);
		wait_drained();

		tx_idle_pct = 37;
		rx_stall_pct = 37;
		add_random_reqs(RANDOM_ITEMS / 4);
		wait_drained();

		rx_stall_pct = 0;
		repeat (10) @(posedge clk);
		$display("run covered %0d requests and %0d results across four idling phases",
			reqs_taken, results_taken);
		$display("result status mix: %0d ok, %0d empty, %0d full, %0d bad level",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
			status_seen[ST_BADLEVEL]);
		if (mismatches == 0) begin
			$display("** three_level_priority_fifo_scheduler: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** three_level_priority_fifo_scheduler: FAILED **");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", rsp_expected.size());
		$display("** three_level_priority_fifo_scheduler: FAILED **");
		$finish;
	end

endmodule
